@@ hw/rtl/lcg_pkg.sv @@
package lcg_pkg;

  // Default datapath width of generated values
  localparam int unsigned VALUE_WIDTH_DEF = 64;

  // Configuration port geometry
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 8;

  // Sequence length counter width
  localparam int unsigned RUN_W = 32;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MULTIPLIER = 8'd0,
    CFG_INCREMENT  = 8'd1,
    CFG_MODULUS    = 8'd2,
    CFG_SEED       = 8'd3,
    CFG_RUN_LENGTH = 8'd4
  } cfg_reg_e;

  // Status from the arithmetic core to the top level
  typedef struct packed {
    logic busy;  // core holds a word in progress
    logic done;  // result ready to be taken
  } core_stat_t;

endpackage

@@ hw/rtl/lcg_addsub.sv @@
module lcg_addsub #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic [VALUE_WIDTH:0]   op_a_i,
  input  logic [VALUE_WIDTH:0]   op_b_i,
  input  logic                   sub_i,
  output logic [VALUE_WIDTH+1:0] res_o
);

  logic [VALUE_WIDTH+1:0] ext_a;
  logic [VALUE_WIDTH+1:0] ext_b;

  assign ext_a = {1'b0, op_a_i};
  assign ext_b = {1'b0, op_b_i};

  // Shared adder; top bit is carry on add, borrow on subtract
  assign res_o = sub_i ? (ext_a - ext_b) : (ext_a + ext_b);

endmodule

@@ hw/rtl/lcg_core.sv @@
module lcg_core import lcg_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] x_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] c_i,
  input  logic [VALUE_WIDTH-1:0] m_i,
  input  logic                   take_i,
  output core_stat_t             stat_o,
  output logic [VALUE_WIDTH-1:0] result_o
);

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned CntW = $clog2(2 * W);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_RED  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2*W:0]    prod_q, prod_d;
  logic [W-1:0]    res_q, res_d;

  logic [W:0]      op_a, op_b;
  logic            op_sub;
  logic [W+1:0]    alu_res;
  logic [W:0]      rem_t;

  // Partial remainder with the next product bit shifted in
  assign rem_t = {res_q, prod_q[2*W-1]};

  // Operand select for the shared adder
  always_comb begin
    op_a   = prod_q[2*W:W];
    op_b   = {1'b0, a_i};
    op_sub = 1'b0;
    if (state_q == ST_RED) begin
      op_a   = rem_t;
      op_b   = {1'b0, m_i};
      op_sub = 1'b1;
    end
  end

  lcg_addsub #(
    .VALUE_WIDTH(W)
  ) u_addsub (
    .op_a_i(op_a),
    .op_b_i(op_b),
    .sub_i (op_sub),
    .res_o (alu_res)
  );

  // Sequencer: shift-add multiply, then restoring reduction or, for a zero modulus, plain wrap
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          // increment preloaded in the high half lands as the addend
          prod_d  = {1'b0, c_i, x_i};
          res_d   = '0;
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d = prod_q[0] ? {1'b0, alu_res[W:0], prod_q[W-1:1]}
                           : {1'b0, prod_q[2*W:1]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntW'(W - 1)) begin
          cnt_d   = '0;
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        if (m_i == '0) begin
          // zero modulus means plain wrap at the value width
          res_d   = prod_q[W-1:0];
          state_d = ST_DONE;
        end else begin
          if (!alu_res[W+1]) begin
            res_d = alu_res[W-1:0];
          end else begin
            res_d = rem_t[W-1:0];
          end
          prod_d = {prod_q[2*W-1:0], 1'b0};
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q == CntW'(2 * W - 1)) begin
            cnt_d   = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);
  assign result_o    = res_q;

endmodule

@@ hw/rtl/lcg_sequence_generator.sv @@
// LCG sequence generator: x' = (a*x + c) mod m over an exact double-width
// product, with a sequence length counter.
//
// Channels: the input channel (in_valid_i/in_ready_o) carries one word, the
// restart bit, per requested value. The output channel (out_valid_o/
// out_ready_i) returns next_value_o and last_o, one word per request. The
// configuration channel (cfg_valid_i/cfg_ready_o) writes multiplier,
// increment, modulus, seed and run length by index; it is always ready and
// should only be used while no request is outstanding.
//
// Sequencing: the result reaches the output register after the multiply and
// the reduction; a new request is taken only once the core has passed its
// result on to the output register. The shared adder is used once per cycle:
// VALUE_WIDTH shift-add steps, then 2*VALUE_WIDTH restoring reduction steps.
// A zero modulus skips the reduction.
//
// Reset sets the config and sequence registers to defaults (modulus and run length 1,
// others 0) and starts a new sequence on the first request. If the receiver
// stalls, the result holds in the output register; the next request may be
// accepted and computed, then waits in the core until the register frees.
module lcg_sequence_generator import lcg_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   restart_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0] next_value_o,
  output logic                   last_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned W = VALUE_WIDTH;

  logic [W-1:0]     mult_q, inc_q, mod_q, seed_q;
  logic [RUN_W-1:0] run_len_q;
  logic [W-1:0]     cur_q;
  logic [RUN_W-1:0] count_q, count_d;
  logic             last_pend_q;
  logic             out_valid_q;
  logic [W-1:0]     out_value_q;
  logic             out_last_q;

  logic             in_fire;
  logic             seq_start;
  logic [RUN_W-1:0] count_base, count_nxt;
  logic             is_last;
  logic [W-1:0]     core_x;
  logic             core_take;
  core_stat_t       core_stat;
  logic [W-1:0]     core_result;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !core_stat.busy;
  assign in_fire     = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q    <= '0;
      inc_q     <= '0;
      mod_q     <= W'(1);
      seed_q    <= '0;
      run_len_q <= RUN_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MULTIPLIER: mult_q    <= cfg_data_i[W-1:0];
        CFG_INCREMENT:  inc_q     <= cfg_data_i[W-1:0];
        CFG_MODULUS:    mod_q     <= cfg_data_i[W-1:0];
        CFG_SEED:       seed_q    <= cfg_data_i[W-1:0];
        CFG_RUN_LENGTH: run_len_q <= cfg_data_i[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence position; a zero length acts as one
  assign seq_start  = restart_i || (count_q == '0);
  assign count_base = seq_start ? '0 : count_q;
  assign count_nxt  = count_base + 1'b1;
  assign is_last    = (count_nxt >= run_len_q) || (count_nxt == '0);
  assign count_d    = is_last ? '0 : count_nxt;
  assign core_x     = seq_start ? seed_q : cur_q;

  // Result moves to the output register once it is free
  assign core_take = core_stat.done && (!out_valid_q || out_ready_i);

  lcg_core #(
    .VALUE_WIDTH(W)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .x_i     (core_x),
    .a_i     (mult_q),
    .c_i     (inc_q),
    .m_i     (mod_q),
    .take_i  (core_take),
    .stat_o  (core_stat),
    .result_o(core_result)
  );

  // Sequence state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cur_q       <= '0;
      last_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        last_pend_q <= is_last;
      end
      if (core_take) begin
        cur_q       <= core_result;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (core_take) begin
      out_value_q <= core_result;
      out_last_q  <= last_pend_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_value_o = out_value_q;
  assign last_o       = out_last_q;

endmodule

@@ hw/rtl/lcg_checker.sv @@
module lcg_assertions import lcg_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [VALUE_WIDTH-1:0] next_value_o,
  input logic                   last_o
);

  // Accepted word keeps the core busy, so input ready drops after the accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o ##1 !in_ready_o))
    else $error("input ready too soon after accept");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(next_value_o) && $stable(last_o)))
    else $error("output word changed while stalled");

  // A new result only comes from a busy core
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without work in progress");

  // No result can appear right after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o))
    else $error("result appeared in the cycle after accept");

endmodule

bind lcg_sequence_generator lcg_assertions #(.VALUE_WIDTH(VALUE_WIDTH)) u_lcg_assertions (.*);

@@ dv/lcg_checker.sv @@
`timescale 1ns / 1ps

// Watches the request, result and register channels of the LCG generator,
// keeps its own copy of the registers and the sequence state, and compares
// every returned word with the value the recurrence predicts.
module lcg_checker import lcg_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   restart_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [VALUE_WIDTH-1:0] next_value_i,
  input  logic                   last_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;
  } lcg_word_t;

  // Register copies, at the datapath width (run length at the counter width)
  logic [VALUE_WIDTH-1:0] mult_reg, incr_reg, mod_reg, seed_reg;
  logic [RUN_W-1:0]       run_len_reg;

  // Sequence state
  logic [VALUE_WIDTH-1:0] seq_value;
  logic [RUN_W-1:0]       seq_count;

  lcg_word_t expected_words[$];
  lcg_word_t want;
  int        mismatches;

  // Next value of the recurrence over the exact double-width product;
  // a zero modulus means plain truncation to the value width.
  function automatic lcg_word_t next_lcg_word(input logic restart);
    logic [VALUE_WIDTH-1:0]   x;
    logic [2*VALUE_WIDTH-1:0] acc;
    logic [2*VALUE_WIDTH-1:0] rem;
    lcg_word_t                w;
    if (restart || seq_count == '0) begin
      x = seed_reg;
      seq_count = '0;
    end else begin
      x = seq_value;
    end
    acc = {{VALUE_WIDTH{1'b0}}, mult_reg} * {{VALUE_WIDTH{1'b0}}, x}
        + {{VALUE_WIDTH{1'b0}}, incr_reg};
    if (mod_reg == '0) begin
      w.value = acc[VALUE_WIDTH-1:0];
    end else begin
      rem = acc % {{VALUE_WIDTH{1'b0}}, mod_reg};
      w.value = rem[VALUE_WIDTH-1:0];
    end
    seq_value = w.value;
    seq_count = seq_count + 1'b1;
    // a zero run length (or a wrapped count) ends every sequence at once
    w.last = (seq_count >= run_len_reg) || (seq_count == '0);
    if (w.last) seq_count = '0;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_reg    = '0;
      incr_reg    = '0;
      mod_reg     = VALUE_WIDTH'(1);
      seed_reg    = '0;
      run_len_reg = RUN_W'(1);
      seq_value   = '0;
      seq_count   = '0;
      expected_words.delete();
      mismatches  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MULTIPLIER: mult_reg    = cfg_data_i[VALUE_WIDTH-1:0];
          CFG_INCREMENT:  incr_reg    = cfg_data_i[VALUE_WIDTH-1:0];
          CFG_MODULUS:    mod_reg     = cfg_data_i[VALUE_WIDTH-1:0];
          CFG_SEED:       seed_reg    = cfg_data_i[VALUE_WIDTH-1:0];
          CFG_RUN_LENGTH: run_len_reg = cfg_data_i[RUN_W-1:0];
          default: ;
        endcase
      end

      // returned word against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: unexpected word value %h last %b", $realtime,
                     next_value_i, last_i);
        end else begin
          want = expected_words.pop_front();
          if (next_value_i !== want.value || last_i !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t: word mismatch: value exp %h got %h, last exp %b got %b",
                       $realtime, want.value, next_value_i, want.last, last_i);
          end
        end
      end

      // new request
      if (in_valid_i && in_ready_i)
        expected_words.push_back(next_lcg_word(restart_i));

      fail_count_o <= mismatches;
      pending_o    <= expected_words.size();
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import lcg_pkg::*;

  localparam int unsigned VW          = VALUE_WIDTH_DEF;
  localparam int          TOTAL_WORDS = 1050;
  localparam int          IDLE_LIMIT  = 20000;
  localparam int          DRAIN_WAIT  = 3 * VW + 20;
  // highest index of the port, far past the register list
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  restart_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [VW-1:0]         next_value_o;
  logic                  last_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int fail_count;
  int pending;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  reg_write_t reg_plan[$];
  logic       restart_plan[$];
  bit         idle_on = 1'b1;
  int         stall_left = 0;
  int         words_sent = 0;
  int         idle_cycles = 0;

  lcg_sequence_generator u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .restart_i,
    .out_valid_o, .out_ready_i, .next_value_o, .last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  lcg_checker #(.VALUE_WIDTH(VW)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .restart_i,
    .out_valid_i(out_valid_o), .out_ready_i, .next_value_i(next_value_o),
    .last_i(last_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 400);
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1;
      3: return 64'd1 << $urandom_range(0, 63);
      4: return 64'($urandom_range(0, 1000));
      5: return {32'd0, 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // short runs mostly, so that sequence ends come often
  function automatic logic [63:0] pick_run();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 64'hFFFF_FFFF;
      2: return {32'($urandom), 32'($urandom)};
      default: return 64'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    reg_plan.push_back('{idx: idx, data: data});
  endtask

  // register writes; valid stays up between back-to-back words
  task automatic write_regs();
    int         gap;
    reg_write_t w;
    while (reg_plan.size() != 0) begin
      w = reg_plan.pop_front();
      gap = pick_gap();
      if (gap != 0) begin
        cfg_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i  <= w.data;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // requests from the restart plan
  task automatic send_words();
    int gap;
    while (restart_plan.size() != 0) begin
      gap = pick_gap();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      restart_i  <= restart_plan.pop_front();
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      words_sent++;
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic run_plan();
    write_regs();
    send_words();
    wait_drain();
  endtask

  // random settings, then a burst of mostly unbroken sequences
  task automatic random_phase();
    int n;
    int pct;
    idle_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 3) != 0) queue_reg(CFG_MULTIPLIER, pick_word());
    if ($urandom_range(0, 3) != 0) queue_reg(CFG_INCREMENT, pick_word());
    if ($urandom_range(0, 3) != 0) queue_reg(CFG_MODULUS, pick_word());
    if ($urandom_range(0, 3) != 0) queue_reg(CFG_SEED, pick_word());
    if ($urandom_range(0, 3) != 0) queue_reg(CFG_RUN_LENGTH, pick_run());
    if ($urandom_range(0, 9) == 0)
      queue_reg(CFG_IDX_W'($urandom_range(int'(CFG_RUN_LENGTH) + 1, int'(CFG_IDX_TOP))),
                pick_word());
    pct = ($urandom_range(0, 4) == 0) ? 30 : 5;
    n = $urandom_range(20, 60);
    repeat (n) restart_plan.push_back($urandom_range(0, 99) < pct);
    run_plan();
  endtask

  // result side: alternating ready and stall stretches, or always ready with idling off
  always @(posedge clk_i) begin
    if (!idle_on) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_ready_i <= !out_ready_i;
      stall_left  <= pick_gap();
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: everything reduces to zero, every word is last
    restart_plan = '{1'b0, 1'b1};
    run_plan();

    // all-ones operands, seed above the modulus
    idle_on = 1'b0;
    queue_reg(CFG_MULTIPLIER, '1);
    queue_reg(CFG_INCREMENT, '1);
    queue_reg(CFG_MODULUS, 64'hFFFF_FFFF_FFFF_FFFE);
    queue_reg(CFG_SEED, '1);
    queue_reg(CFG_RUN_LENGTH, 64'd3);
    restart_plan = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    run_plan();

    // zero modulus wraps at the value width; zero run length
    idle_on = 1'b1;
    queue_reg(CFG_MULTIPLIER, 64'h5851_F42D_4C95_7F2D);
    queue_reg(CFG_INCREMENT, 64'h1405_7B7E_F767_814F);
    queue_reg(CFG_MODULUS, '0);
    queue_reg(CFG_RUN_LENGTH, '0);
    restart_plan = '{1'b0, 1'b0, 1'b1};
    run_plan();

    // longest run, plus a write to an index past the list
    queue_reg(CFG_MULTIPLIER, 64'd1);
    queue_reg(CFG_MODULUS, '1);
    queue_reg(CFG_SEED, '0);
    queue_reg(CFG_RUN_LENGTH, 64'hFFFF_FFFF);
    queue_reg(CFG_IDX_TOP, '1);
    restart_plan = '{1'b0, 1'b0, 1'b0};
    run_plan();

    // seed written mid-sequence only applies at the next start
    queue_reg(CFG_SEED, 64'h8000_0000_0000_0000);
    queue_reg(CFG_MULTIPLIER, 64'h8000_0000_0000_0000);
    queue_reg(CFG_INCREMENT, '0);
    queue_reg(CFG_MODULUS, 64'h8000_0000_0000_0001);
    restart_plan = '{1'b0, 1'b0};
    run_plan();

    // run length shrunk below the count already reached
    queue_reg(CFG_RUN_LENGTH, 64'd4);
    restart_plan = '{1'b0, 1'b0, 1'b0, 1'b0};
    run_plan();

    queue_reg(CFG_SEED, 64'h0123_4567_89AB_CDEF);
    restart_plan = '{1'b0, 1'b1};
    run_plan();

    while (words_sent < TOTAL_WORDS) random_phase();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
